FILE: sv/serial_mouse_three_byte_reporter_defines.svh
// assertion macros for the serial mouse reporter
// expects signals clk and rst in the scope of each use
`ifndef SERIAL_MOUSE_THREE_BYTE_REPORTER_DEFINES_SVH
`define SERIAL_MOUSE_THREE_BYTE_REPORTER_DEFINES_SVH

// antecedent holds in the same cycle as the consequent
`define SMTBR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smtbr assertion failed");

// consequent holds in the cycle after the antecedent
`define SMTBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smtbr assertion failed");

`endif

FILE: sv/smtbr_pkg.sv
// package for the serial mouse reporter: widths, codes, byte burst type
// and the axis arithmetic helpers; depends on nothing
package smtbr_pkg;

  localparam int AXIS_BITS  = 12;
  localparam int ACCUM_BITS = 16;
  localparam int DIFF_BITS  = AXIS_BITS + 1;
  localparam int SUM_BITS   = ((ACCUM_BITS > DIFF_BITS) ? ACCUM_BITS : DIFF_BITS) + 1;

  localparam int CHAR_BITS = 7;
  localparam int MAX_BYTES = 6;
  localparam int CNT_BITS  = $clog2(MAX_BYTES + 1);
  localparam int MODE_BITS = 2;
  localparam int BTN_BITS  = 3;

  // protocol modes
  localparam logic [MODE_BITS-1:0] MODE_TWO   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_THREE = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_WHEEL = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_RSVD  = 2'd3;

  // identification characters
  localparam logic [CHAR_BITS-1:0] CHR_M   = 7'h4d;
  localparam logic [CHAR_BITS-1:0] CHR_3   = 7'h33;
  localparam logic [CHAR_BITS-1:0] CHR_Z   = 7'h5a;
  localparam logic [CHAR_BITS-1:0] CHR_AT  = 7'h40;
  localparam logic [CHAR_BITS-1:0] CHR_NUL = 7'h00;

  localparam logic signed [DIFF_BITS-1:0] AXIS_HALF = DIFF_BITS'(1) << (AXIS_BITS - 1);
  localparam logic signed [DIFF_BITS-1:0] AXIS_FULL = DIFF_BITS'(1) << AXIS_BITS;

  localparam logic signed [SUM_BITS-1:0] ACC_MAX_WIDE =
      (SUM_BITS'(1) << (ACCUM_BITS - 1)) - SUM_BITS'(1);
  localparam logic signed [SUM_BITS-1:0] ACC_MIN_WIDE = ~ACC_MAX_WIDE;

  localparam logic signed [ACCUM_BITS-1:0] XY_HI  = ACCUM_BITS'(127);
  localparam logic signed [ACCUM_BITS-1:0] XY_LO  = ~XY_HI;
  localparam logic signed [ACCUM_BITS-1:0] WHL_HI = ACCUM_BITS'(7);
  localparam logic signed [ACCUM_BITS-1:0] WHL_LO = ~WHL_HI;

  typedef logic signed [ACCUM_BITS-1:0] accum_t;
  typedef logic [AXIS_BITS-1:0]         axis_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]                     count;
    logic [MAX_BYTES-1:0][CHAR_BITS-1:0]     bytes;
  } burst_t;

  // wrapped counter difference; a half-turn backwards reads as +half
  function automatic logic signed [DIFF_BITS-1:0] axis_diff(input axis_t now,
                                                           input axis_t last);
    logic signed [DIFF_BITS-1:0] d;
    d = $signed({1'b0, now}) - $signed({1'b0, last});
    if (d >= AXIS_HALF) begin
      d = d - AXIS_FULL;
    end else if (d <= -AXIS_HALF) begin
      d = d + AXIS_FULL;
    end
    return d;
  endfunction

  // saturating accumulate
  function automatic accum_t sat_add(input accum_t acc,
                                     input logic signed [DIFF_BITS-1:0] d);
    logic signed [SUM_BITS-1:0] s;
    s = SUM_BITS'(acc) + SUM_BITS'(d);
    if (s > ACC_MAX_WIDE) begin
      s = ACC_MAX_WIDE;
    end
    if (s < ACC_MIN_WIDE) begin
      s = ACC_MIN_WIDE;
    end
    return ACCUM_BITS'(s);
  endfunction

  function automatic accum_t clip(input accum_t acc, input accum_t lo, input accum_t hi);
    accum_t v;
    v = acc;
    if (v < lo) begin
      v = lo;
    end
    if (v > hi) begin
      v = hi;
    end
    return v;
  endfunction

endpackage

FILE: sv/smtbr_ifs.sv
// valid/ready channel interfaces of the serial mouse reporter
// depends on smtbr_pkg
interface smtbr_snap_if;
  logic                          valid;
  logic                          ready;
  logic                          dtr_line;
  logic                          rts_line;
  logic [smtbr_pkg::AXIS_BITS-1:0] x_position;
  logic [smtbr_pkg::AXIS_BITS-1:0] y_position;
  logic [smtbr_pkg::AXIS_BITS-1:0] wheel_position;
  logic [smtbr_pkg::BTN_BITS-1:0]  buttons;

  modport source (output valid, dtr_line, rts_line, x_position, y_position,
                  wheel_position, buttons, input ready);
  modport sink (input valid, dtr_line, rts_line, x_position, y_position,
                wheel_position, buttons, output ready);
endinterface

interface smtbr_byte_if;
  logic                            valid;
  logic                            ready;
  logic [smtbr_pkg::CHAR_BITS-1:0] serial_byte;
  logic                            last_byte;

  modport source (output valid, serial_byte, last_byte, input ready);
  modport sink (input valid, serial_byte, last_byte, output ready);
endinterface

interface smtbr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [smtbr_pkg::MODE_BITS-1:0] protocol_mode;

  modport source (output valid, protocol_mode, input ready);
  modport sink (input valid, protocol_mode, output ready);
endinterface

FILE: sv/smtbr_engine.sv
// snapshot register, mouse state and report builder
// depends on smtbr_pkg and smtbr_snap_if
module smtbr_engine (
  input  logic                            clk,
  input  logic                            rst,
  smtbr_snap_if.sink                      snap,
  input  logic [smtbr_pkg::MODE_BITS-1:0] mode,
  input  logic                            burst_free,
  output smtbr_pkg::burst_t               burst,
  output logic                            burst_load
);

  // snapshot register
  logic                            snap_valid;
  logic                            dtr_q;
  logic                            rts_q;
  smtbr_pkg::axis_t                x_q;
  smtbr_pkg::axis_t                y_q;
  smtbr_pkg::axis_t                w_q;
  logic [smtbr_pkg::BTN_BITS-1:0]  btn_q;

  // mouse state
  logic                            enabled, enabled_next;
  smtbr_pkg::axis_t                x_last, x_last_next;
  smtbr_pkg::axis_t                y_last, y_last_next;
  smtbr_pkg::axis_t                wheel_last, wheel_last_next;
  smtbr_pkg::accum_t               x_accum, x_accum_next;
  smtbr_pkg::accum_t               y_accum, y_accum_next;
  smtbr_pkg::accum_t               wheel_accum, wheel_accum_next;
  logic [smtbr_pkg::BTN_BITS-1:0]  buttons_sent, buttons_sent_next;

  logic                            fire;
  logic                            want;
  logic                            wheel_on;
  logic                            mid_any;
  logic                            report;
  logic [smtbr_pkg::MODE_BITS-1:0] mode_eff;
  smtbr_pkg::accum_t               sx, sy, sw;
  smtbr_pkg::accum_t               cx, cy, cw;
  smtbr_pkg::burst_t               b;

  assign fire      = snap_valid && burst_free;
  assign snap.ready = !snap_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap.valid && snap.ready) begin
      snap_valid <= 1'b1;
    end else if (fire) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap.valid && snap.ready) begin
      dtr_q <= snap.dtr_line;
      rts_q <= snap.rts_line;
      x_q   <= snap.x_position;
      y_q   <= snap.y_position;
      w_q   <= snap.wheel_position;
      btn_q <= snap.buttons;
    end
  end

  assign mode_eff = (mode == smtbr_pkg::MODE_RSVD) ? smtbr_pkg::MODE_TWO : mode;
  assign want     = !dtr_q && !rts_q;
  assign wheel_on = (mode_eff == smtbr_pkg::MODE_WHEEL);
  assign mid_any  = btn_q[2] || buttons_sent[2];

  assign sx = smtbr_pkg::sat_add(x_accum, smtbr_pkg::axis_diff(x_q, x_last));
  assign sy = smtbr_pkg::sat_add(y_accum, smtbr_pkg::axis_diff(y_q, y_last));
  assign sw = smtbr_pkg::sat_add(wheel_accum, smtbr_pkg::axis_diff(w_q, wheel_last));
  assign cx = smtbr_pkg::clip(sx, smtbr_pkg::XY_LO, smtbr_pkg::XY_HI);
  assign cy = smtbr_pkg::clip(sy, smtbr_pkg::XY_LO, smtbr_pkg::XY_HI);
  assign cw = smtbr_pkg::clip(sw, smtbr_pkg::WHL_LO, smtbr_pkg::WHL_HI);

  assign report = (sx != '0) || (sy != '0) || (btn_q != buttons_sent) ||
                  (wheel_on && (sw != '0));

  always_comb begin
    enabled_next      = enabled;
    x_last_next       = x_last;
    y_last_next       = y_last;
    wheel_last_next   = wheel_last;
    x_accum_next      = x_accum;
    y_accum_next      = y_accum;
    wheel_accum_next  = wheel_accum;
    buttons_sent_next = buttons_sent;
    b                 = '0;
    if (want != enabled) begin
      enabled_next = want;
      if (want) begin
        // enable turning on: resample, clear, identify
        x_last_next       = x_q;
        y_last_next       = y_q;
        x_accum_next      = '0;
        y_accum_next      = '0;
        buttons_sent_next = btn_q;
        b.bytes[0]        = smtbr_pkg::CHR_M;
        unique case (mode_eff)
          smtbr_pkg::MODE_THREE: begin
            b.bytes[1] = smtbr_pkg::CHR_3;
            b.count    = smtbr_pkg::CNT_BITS'(2);
          end
          smtbr_pkg::MODE_WHEEL: begin
            wheel_last_next  = w_q;
            wheel_accum_next = '0;
            b.bytes[1]       = smtbr_pkg::CHR_Z;
            b.bytes[2]       = smtbr_pkg::CHR_AT;
            b.bytes[3]       = smtbr_pkg::CHR_NUL;
            b.bytes[4]       = smtbr_pkg::CHR_NUL;
            b.bytes[5]       = smtbr_pkg::CHR_NUL;
            b.count          = smtbr_pkg::CNT_BITS'(6);
          end
          default: begin
            b.count = smtbr_pkg::CNT_BITS'(1);
          end
        endcase
      end
    end else if (enabled) begin
      x_last_next  = x_q;
      y_last_next  = y_q;
      x_accum_next = sx;
      y_accum_next = sy;
      if (wheel_on) begin
        wheel_last_next  = w_q;
        wheel_accum_next = sw;
      end
      if (report) begin
        x_accum_next      = sx - cx;
        y_accum_next      = sy - cy;
        buttons_sent_next = btn_q;
        b.bytes[0] = {1'b1, btn_q[1], btn_q[0], cy[7:6], cx[7:6]};
        b.bytes[1] = {1'b0, cx[5:0]};
        b.bytes[2] = {1'b0, cy[5:0]};
        b.count    = smtbr_pkg::CNT_BITS'(3);
        if (mode_eff == smtbr_pkg::MODE_THREE && mid_any) begin
          b.bytes[3] = {1'b0, btn_q[2], 5'b0};
          b.count    = smtbr_pkg::CNT_BITS'(4);
        end else if (wheel_on && (mid_any || sw != '0)) begin
          wheel_accum_next = sw - cw;
          b.bytes[3]       = {2'b0, btn_q[2], cw[3:0]};
          b.count          = smtbr_pkg::CNT_BITS'(4);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled      <= 1'b0;
      x_last       <= '0;
      y_last       <= '0;
      wheel_last   <= '0;
      x_accum      <= '0;
      y_accum      <= '0;
      wheel_accum  <= '0;
      buttons_sent <= '0;
    end else if (fire) begin
      enabled      <= enabled_next;
      x_last       <= x_last_next;
      y_last       <= y_last_next;
      wheel_last   <= wheel_last_next;
      x_accum      <= x_accum_next;
      y_accum      <= y_accum_next;
      wheel_accum  <= wheel_accum_next;
      buttons_sent <= buttons_sent_next;
    end
  end

  assign burst      = b;
  assign burst_load = fire && (b.count != '0);

endmodule

FILE: sv/smtbr_serializer.sv
// byte burst register, shifted out one character per request
// depends on smtbr_pkg and smtbr_byte_if
module smtbr_serializer (
  input  logic              clk,
  input  logic              rst,
  input  smtbr_pkg::burst_t burst,
  input  logic              burst_load,
  output logic              burst_free,
  smtbr_byte_if.source      report
);

  logic [smtbr_pkg::MAX_BYTES-1:0][smtbr_pkg::CHAR_BITS-1:0] bytes;
  logic [smtbr_pkg::CNT_BITS-1:0]                            remain;
  logic                                                      take;

  assign report.valid       = (remain != '0);
  assign report.serial_byte = bytes[0];
  assign report.last_byte   = (remain == smtbr_pkg::CNT_BITS'(1));
  assign take               = report.valid && report.ready;
  assign burst_free         = (remain == '0) || (take && report.last_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (burst_load) begin
      remain <= burst.count;
    end else if (take) begin
      remain <= remain - smtbr_pkg::CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (burst_load) begin
      bytes <= burst.bytes;
    end else if (take) begin
      bytes <= {smtbr_pkg::CHAR_BITS'(0), bytes[smtbr_pkg::MAX_BYTES-1:1]};
    end
  end

endmodule

FILE: sv/serial_mouse_three_byte_reporter.sv
// serial mouse reporter: snapshot in, seven-bit characters out
// path: an accepted snapshot waits in the snapshot register until the shifter is free,
// then its n characters (n=1..6) load into the shifter, which sends one per ready cycle
// throughput: one snapshot per cycle while no characters result and the shifter is free
// reset: synchronous active-high rst clears enable, counters, accumulators and mode
// depends on smtbr_pkg, smtbr_ifs, smtbr_engine, smtbr_serializer and the defines header
`include "serial_mouse_three_byte_reporter_defines.svh"

module serial_mouse_three_byte_reporter (
  input  logic         clk,
  input  logic         rst,
  smtbr_snap_if.sink   snapshot,
  smtbr_byte_if.source report,
  smtbr_cfg_if.sink    cfg
);

  // protocol mode register; the user must write it only while the block is idle (not enforced)
  logic [smtbr_pkg::MODE_BITS-1:0] protocol_mode;

  // burst handover between the report builder and the character shifter
  smtbr_pkg::burst_t burst;
  logic              burst_load;
  logic              burst_free;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_mode <= smtbr_pkg::MODE_TWO;
    end else if (cfg.valid && cfg.ready) begin
      protocol_mode <= cfg.protocol_mode;
    end
  end

  // snapshot register plus the single-pass state update and byte packing
  smtbr_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .snap       (snapshot),
    .mode       (protocol_mode),
    .burst_free (burst_free),
    .burst      (burst),
    .burst_load (burst_load)
  );

  // holds up to six characters; frees itself as the last one is taken
  smtbr_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .burst      (burst),
    .burst_load (burst_load),
    .burst_free (burst_free),
    .report     (report)
  );

  // a burst is never loaded over characters still waiting
  `SMTBR_ASSERT_SAME(a_load_when_free, burst_load, burst_free)
  // a loaded burst is never empty and never too long
  `SMTBR_ASSERT_SAME(a_burst_len, burst_load,
    (burst.count != '0) && (burst.count <= smtbr_pkg::CNT_BITS'(smtbr_pkg::MAX_BYTES)))
  // a loaded burst shows up on the output the next cycle
  `SMTBR_ASSERT_NEXT(a_load_shows, burst_load, report.valid)
  // taking the last byte with nothing new loaded leaves the output empty
  `SMTBR_ASSERT_NEXT(a_last_drains,
    report.valid && report.ready && report.last_byte && !burst_load, !report.valid)

endmodule
